/* hw/rtl/tcpc_pkg.sv */
`default_nettype none

package tcpc_pkg;

    localparam int ROW_COLS    = 32;
    localparam int ROW_INDEX_W = 5;
    localparam int COUNT_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_FETCH,
        ST_EVAL,
        ST_ENQ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/tcpc_row_store.sv */
`default_nettype none

module tcpc_row_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [tcpc_pkg::ROW_COLS-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [tcpc_pkg::ROW_COLS-1:0] rd_data
);

    logic [tcpc_pkg::ROW_COLS-1:0] mem [DEPTH];
    logic [tcpc_pkg::ROW_COLS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/tcpc_walk_queue.sv */
`default_nettype none

module tcpc_walk_queue #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcpc_pkg::q_ctrl_t ctrl,
    input  wire logic [AW-1:0]     push_data,
    output logic      [AW-1:0]     pop_data,
    output logic                   empty
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] pop_data_reg;
    logic [AW:0]   head_reg;
    logic [AW:0]   head_next;
    logic [AW:0]   tail_reg;
    logic [AW:0]   tail_next;
    logic [AW-1:0] wr_addr;

    // a clear restarts the walk; a push in the same cycle lands in entry zero
    assign wr_addr = ctrl.clear ? '0 : tail_reg[AW-1:0];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            tail_next = ctrl.push ? (AW+1)'(1) : '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                tail_next = tail_reg + (AW+1)'(1);
            end
            if (ctrl.pop)
            begin
                head_next = head_reg + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_addr] <= push_data;
        end
        if (ctrl.pop)
        begin
            pop_data_reg <= mem[head_reg[AW-1:0]];
        end
    end

    assign pop_data = pop_data_reg;
    assign empty    = (head_reg == tail_reg);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && !ctrl.clear) |-> (tail_reg < (AW+1)'(DEPTH)))
        else $error("walk queue pushed past its depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.pop && !ctrl.clear) |-> !empty)
        else $error("walk queue popped while empty");
`endif

endmodule

`default_nettype wire

/* hw/rtl/two_clique_partition_check_core.sv */
`default_nettype none

// Rows are accepted while idle. After the last row the check passes through a clear
// step, then per walk a seed and a closing empty pop, a last seed and a done step, and per
// visited vertex a pop, fetch and evaluate plus one queue step per discovered vertex and one
// to finish when it found any; a conflict goes straight to done, which waits for the output.
// The result waits in an output register; the next row is taken once the check is done.
// rst_n is asynchronous and active low: count cleared, queue empty, no result pending.
module two_clique_partition_check_core #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // row_index[4:0], row_bits[36:5], zero pad
    input  wire logic        s_tlast,    // last_row
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,    // two_cliques[0], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data    // vertex_count
);

    localparam int COLS = (MAX_VERTICES < tcpc_pkg::ROW_COLS) ? MAX_VERTICES
                                                              : tcpc_pkg::ROW_COLS;
    localparam int AW   = (COLS > 1) ? $clog2(COLS) : 1;

    tcpc_pkg::state_t  state_reg;
    tcpc_pkg::state_t  state_next;
    tcpc_pkg::q_ctrl_t q_ctrl;

    logic [tcpc_pkg::COUNT_W-1:0]     count_reg;
    logic [tcpc_pkg::ROW_INDEX_W-1:0] row_index;
    logic [tcpc_pkg::ROW_COLS-1:0]    row_bits;
    logic                             in_accept;
    logic                             row_wr_en;

    logic [COLS-1:0] active_reg;
    logic [COLS-1:0] active_mask;
    logic [COLS-1:0] coloured_reg;
    logic [COLS-1:0] colour_reg;
    logic [COLS-1:0] pend_reg;
    logic [AW-1:0]   u_reg;
    logic            answer_reg;
    logic            out_valid_reg;
    logic            out_bit_reg;

    logic [COLS-1:0] free_mask;
    logic [AW-1:0]   seed_idx;
    logic            seed_found;
    logic [AW-1:0]   pend_idx;
    logic [COLS-1:0] nonedge;
    logic [COLS-1:0] new_mask;
    logic            conflict;
    logic            cu;
    logic            out_load;

    logic                          row_rd_en;
    logic [AW-1:0]                 row_rd_addr;
    logic [tcpc_pkg::ROW_COLS-1:0] row_rd_data;
    logic [AW-1:0]                 q_push_data;
    logic [AW-1:0]                 q_pop_data;
    logic                          q_empty;

    assign row_index = s_tdata[4:0];
    assign row_bits  = s_tdata[36:5];
    assign in_accept = s_tvalid && s_tready;
    assign row_wr_en = in_accept && ({1'b0, row_index} < 6'(COLS));

    tcpc_row_store #(
        .DEPTH (COLS),
        .AW    (AW)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (row_index[AW-1:0]),
        .wr_data (row_bits),
        .rd_en   (row_rd_en),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    tcpc_walk_queue #(
        .DEPTH (COLS),
        .AW    (AW)
    ) u_walk_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    always_comb
    begin
        for (int i = 0; i < COLS; i++)
        begin
            active_mask[i] = (count_reg > 6'(i));
        end
    end

    assign free_mask  = active_reg & ~coloured_reg;
    assign seed_found = |free_mask;

    // lowest uncolored vertex seeds the next walk
    always_comb
    begin
        seed_idx = '0;
        for (int i = COLS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                seed_idx = AW'(i);
            end
        end
    end

    // discovered vertices enter the queue in ascending order
    always_comb
    begin
        pend_idx = '0;
        for (int i = COLS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pend_idx = AW'(i);
            end
        end
    end

    assign cu = colour_reg[u_reg];

    always_comb
    begin
        for (int i = 0; i < COLS; i++)
        begin
            nonedge[i] = active_reg[i] && (AW'(i) != u_reg) && !row_rd_data[i];
        end
    end

    assign conflict = |(nonedge & coloured_reg & ~(colour_reg ^ {COLS{cu}}));
    assign new_mask = nonedge & ~coloured_reg;
    assign out_load = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcpc_pkg::ST_IDLE:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = tcpc_pkg::ST_CLEAR;
                end
            end
            tcpc_pkg::ST_CLEAR:
            begin
                state_next = tcpc_pkg::ST_SEED;
            end
            tcpc_pkg::ST_SEED:
            begin
                state_next = seed_found ? tcpc_pkg::ST_POP : tcpc_pkg::ST_DONE;
            end
            tcpc_pkg::ST_POP:
            begin
                state_next = q_empty ? tcpc_pkg::ST_SEED : tcpc_pkg::ST_FETCH;
            end
            tcpc_pkg::ST_FETCH:
            begin
                state_next = tcpc_pkg::ST_EVAL;
            end
            tcpc_pkg::ST_EVAL:
            begin
                if (conflict)
                begin
                    state_next = tcpc_pkg::ST_DONE;
                end
                else if (|new_mask)
                begin
                    state_next = tcpc_pkg::ST_ENQ;
                end
                else
                begin
                    state_next = tcpc_pkg::ST_POP;
                end
            end
            tcpc_pkg::ST_ENQ:
            begin
                if (pend_reg == '0)
                begin
                    state_next = tcpc_pkg::ST_POP;
                end
            end
            tcpc_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tcpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        q_ctrl       = '0;
        q_push_data  = pend_idx;
        row_rd_en    = 1'b0;
        row_rd_addr  = q_pop_data;
        unique case (state_reg)
            tcpc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            tcpc_pkg::ST_SEED:
            begin
                q_ctrl.clear = seed_found;
                q_ctrl.push  = seed_found;
                q_push_data  = seed_idx;
            end
            tcpc_pkg::ST_POP:
            begin
                q_ctrl.pop = !q_empty;
            end
            tcpc_pkg::ST_FETCH:
            begin
                row_rd_en = 1'b1;
            end
            tcpc_pkg::ST_ENQ:
            begin
                q_ctrl.push = (pend_reg != '0);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcpc_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            coloured_reg <= '0;
            colour_reg   <= '0;
            pend_reg     <= '0;
            u_reg        <= '0;
            answer_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                tcpc_pkg::ST_CLEAR:
                begin
                    active_reg   <= active_mask;
                    coloured_reg <= '0;
                end
                tcpc_pkg::ST_SEED:
                begin
                    if (seed_found)
                    begin
                        coloured_reg[seed_idx] <= 1'b1;
                        colour_reg[seed_idx]   <= 1'b1;
                    end
                    else
                    begin
                        answer_reg <= 1'b1;
                    end
                end
                tcpc_pkg::ST_FETCH:
                begin
                    u_reg <= q_pop_data;
                end
                tcpc_pkg::ST_EVAL:
                begin
                    if (conflict)
                    begin
                        answer_reg <= 1'b0;
                    end
                    else
                    begin
                        // color every newly found vertex opposite to its finder
                        coloured_reg <= coloured_reg | new_mask;
                        colour_reg   <= (colour_reg & ~new_mask) | (new_mask & {COLS{~cu}});
                        pend_reg     <= new_mask;
                    end
                end
                tcpc_pkg::ST_ENQ:
                begin
                    pend_reg <= pend_reg & (pend_reg - COLS'(1));
                end
                default:
                begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end
        else if ((state_reg == tcpc_pkg::ST_DONE) && out_load)
        begin
            out_valid_reg <= 1'b1;
            out_bit_reg   <= answer_reg;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_bit_reg};
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == tcpc_pkg::ST_DONE))
        else $error("result raised outside the done state");

    a_enq_drains_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcpc_pkg::ST_ENQ && pend_reg != '0)
        |=> ($countones(pend_reg) == $countones($past(pend_reg)) - 1))
        else $error("enqueue step did not retire exactly one vertex");

    a_colour_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tcpc_pkg::ST_CLEAR)
        |=> ((coloured_reg & $past(coloured_reg)) == $past(coloured_reg)))
        else $error("vertex lost its color during a check");
`endif

endmodule

`default_nettype wire

/* verif/tcpc_partition_checker.sv */
module tcpc_partition_checker #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [39:0]                  s_tdata,    // row_index[4:0], row_bits[36:5], zero pad
    input  logic                         s_tlast,    // last_row
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [7:0]                   m_tdata,    // two_cliques[0], zero pad
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [tcpc_pkg::COUNT_W-1:0] cfg_data,
    output int                           error_count,
    output int                           pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_COLS    = tcpc_pkg::ROW_COLS;
    localparam int ROW_INDEX_W = tcpc_pkg::ROW_INDEX_W;
    localparam int COUNT_W     = tcpc_pkg::COUNT_W;

    localparam logic [1:0] COLOUR_ZERO = 2'd0;
    localparam logic [1:0] COLOUR_ONE  = 2'd1;
    localparam logic [1:0] COLOUR_NONE = 2'd3;

    logic [ROW_COLS-1:0] adjacency_copy [MAX_VERTICES];
    logic [COUNT_W-1:0]  vertex_total;
    bit                  expected_answers [$];

    // Two-colour the complement graph breadth first; a non-edge between equal colours
    // means the vertices cannot split into two cliques.
    function automatic bit splits_into_two_cliques();
        logic [1:0]             colour [ROW_COLS];
        logic [ROW_INDEX_W-1:0] walk [ROW_COLS];
        logic [ROW_COLS-1:0]    row;
        int                     n;
        int                     head;
        int                     tail;
        int                     u;
        n = int'(vertex_total);
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        if (n > ROW_COLS)
            n = ROW_COLS;
        for (int v = 0; v < ROW_COLS; v++)
            colour[v] = COLOUR_NONE;
        for (int s = 0; s < n; s++)
        begin
            if (colour[s] == COLOUR_NONE)
            begin
                head = 0;
                tail = 0;
                colour[s] = COLOUR_ONE;
                walk[tail] = ROW_INDEX_W'(s);
                tail++;
                while (head < tail)
                begin
                    u = int'(walk[head]);
                    head++;
                    row = adjacency_copy[u];
                    for (int i = 0; i < n; i++)
                    begin
                        if (i != u && !row[i])
                        begin
                            if (colour[i] == COLOUR_NONE)
                            begin
                                if (tail < ROW_COLS)
                                begin
                                    walk[tail] = ROW_INDEX_W'(i);
                                    tail++;
                                end
                                colour[i] = (colour[u] == COLOUR_ZERO) ? COLOUR_ONE : COLOUR_ZERO;
                            end
                            else if (colour[i] == colour[u])
                                return 1'b0;
                        end
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    initial
    begin
        error_count = 0;
        pending_results = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [ROW_INDEX_W-1:0] row_sel;
        bit                     want;
        if (!rst_n)
        begin
            vertex_total = '0;
            expected_answers.delete();
            pending_results = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vertex_total = cfg_data;
            // Results are popped before the row of this edge, which cannot be answered yet.
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing expected, got two_cliques %0b",
                             $time, m_tdata[0]);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        error_count++;
                        $display("%0t: two_cliques mismatch, expected %0b, got %0b",
                                 $time, want, m_tdata[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                row_sel = s_tdata[ROW_INDEX_W-1:0];
                if (row_sel < MAX_VERTICES)
                    adjacency_copy[row_sel] = s_tdata[ROW_INDEX_W +: ROW_COLS];
                if (s_tlast)
                    expected_answers.push_back(splits_into_two_cliques());
            end
            pending_results = expected_answers.size();
        end
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_COLS    = tcpc_pkg::ROW_COLS;
    localparam int ROW_INDEX_W = tcpc_pkg::ROW_INDEX_W;
    localparam int COUNT_W     = tcpc_pkg::COUNT_W;

    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 250;
    localparam int TARGET_ITEMS  = 1900;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;    // row_index[4:0], row_bits[36:5], zero pad
    logic                s_tlast;    // last_row
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;    // two_cliques[0], zero pad
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;

    int                  error_count;
    int                  pending_results;
    int                  gap_pct;
    int                  stall_pct;
    int                  items_sent;
    int                  quiet_cycles;
    int                  current_count;
    logic [ROW_COLS-1:0] row_written;
    logic [ROW_COLS-1:0] graph_rows [ROW_COLS];

    two_clique_partition_check_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tcpc_partition_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // End the run when no channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_row(input logic [ROW_INDEX_W-1:0] row_sel,
                            input logic [ROW_COLS-1:0] bits, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, bits, row_sel};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        row_written[row_sel] = 1'b1;
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every answer is back and the last row load has settled.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apply_count(input logic [COUNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        current_count = (int'(value) > ROW_COLS) ? ROW_COLS : int'(value);
    endtask

    // Two cliques split by a random side mask, random cross edges, and sometimes a few
    // cleared bits or a fully random matrix to give the answer no.
    function automatic void build_graph(input int n);
        logic [ROW_COLS-1:0] side;
        logic [ROW_COLS-1:0] row;
        int                  style;
        int                  u;
        int                  i;
        side = $urandom;
        style = $urandom_range(4);
        for (u = 0; u < ROW_COLS; u++)
        begin
            row = $urandom;
            if (style == 1)
                row = row & $urandom;
            else if (style == 2)
                row = row | $urandom;
            else if (style == 3)
                row = '0;
            if (style != 4)
                for (i = 0; i < ROW_COLS; i++)
                    if (side[i] == side[u])
                        row[i] = 1'b1;
            graph_rows[u] = row;
        end
        if (n >= 2 && $urandom_range(1) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                u = $urandom_range(n - 1);
                i = $urandom_range(n - 1);
                if (i != u)
                    graph_rows[u][i] = 1'b0;
            end
        end
    endfunction

    task automatic load_graph(input int n);
        int start;
        int k;
        build_graph(n);
        if (n == 0)
        begin
            send_row(ROW_INDEX_W'($urandom_range(ROW_COLS - 1)), $urandom, 1'b1);
            return;
        end
        start = $urandom_range(n - 1);
        for (k = 0; k < n; k++)
        begin
            // Rows outside the check may arrive in between.
            if (n < ROW_COLS && $urandom_range(9) == 0)
                send_row(ROW_INDEX_W'($urandom_range(ROW_COLS - 1, n)), $urandom, 1'b0);
            send_row(ROW_INDEX_W'((start + k) % n), graph_rows[(start + k) % n],
                     k == n - 1);
        end
    endtask

    initial
    begin
        int                  phase;
        int                  runs;
        int                  pick;
        logic [COUNT_W-1:0]  next_count;
        logic [ROW_COLS-1:0] low_mask;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        gap_pct       = 37;
        stall_pct     = 80;
        items_sent    = 0;
        quiet_cycles  = 0;
        current_count = 0;
        row_written   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero count after reset answers yes whatever is stored.
        send_row(5'd31, 32'hFFFF_FFFF, 1'b1);
        apply_count(6'd1);
        send_row(5'd0, 32'h0000_0000, 1'b1);
        apply_count(6'd2);
        send_row(5'd1, 32'h0000_0000, 1'b0);
        send_row(5'd0, 32'h0000_0000, 1'b1);
        // Asymmetric pair: only row 1 reports the missing edge.
        send_row(5'd0, 32'hFFFF_FFFF, 1'b1);
        apply_count(6'd3);
        send_row(5'd0, 32'h0000_0000, 1'b0);
        send_row(5'd1, 32'h0000_0000, 1'b0);
        send_row(5'd2, 32'h0000_0000, 1'b1);
        send_row(5'd0, 32'hFFFF_FFFC, 1'b0);
        send_row(5'd1, 32'hFFFF_FFFC, 1'b0);
        send_row(5'd2, 32'h0000_0003, 1'b1);
        send_row(5'd16, 32'h5555_AAAA, 1'b0);
        send_row(5'd2, 32'hAAAA_5555, 1'b1);

        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (items_sent < TARGET_ITEMS / 3)
            begin
                gap_pct   = 37;
                stall_pct = 80;
            end
            else if (items_sent < 2 * TARGET_ITEMS / 3)
            begin
                gap_pct   = 80;
                stall_pct = 37;
            end
            else
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (phase == 0)
                next_count = 6'd32;
            else if (phase == 1)
                next_count = 6'd63;
            else if (phase == 2)
                next_count = 6'd0;
            else if (pick < 5)
                next_count = 6'd0;
            else if (pick < 60)
                next_count = COUNT_W'($urandom_range(6, 1));
            else if (pick < 85)
                next_count = COUNT_W'($urandom_range(16, 7));
            else if (pick < 93)
                next_count = COUNT_W'($urandom_range(32, 17));
            else
                next_count = COUNT_W'($urandom_range(63, 33));
            apply_count(next_count);
            runs = $urandom_range(3, 10);
            repeat (runs)
            begin
                pick = $urandom_range(99);
                low_mask = (current_count == ROW_COLS) ? '1
                                                       : ((32'd1 << current_count) - 32'd1);
                if (pick < 75)
                    load_graph(current_count);
                else if (pick < 88)
                    repeat ($urandom_range(1, 4))
                        send_row(ROW_INDEX_W'($urandom_range(ROW_COLS - 1)), $urandom, 1'b0);
                else if ((row_written & low_mask) == low_mask)
                    send_row(ROW_INDEX_W'($urandom_range(ROW_COLS - 1)), $urandom, 1'b1);
                if ($urandom_range(14) == 0)
                    drain_results();
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        pick = 0;
        while (pending_results != 0 && pick < DRAIN_LIMIT)
        begin
            @(negedge clk);
            pick++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
